>>> hw/rtl/sitoa_pkg.sv
// ----------------------------------------------------------------------------
// sitoa_pkg: shared types and constants
// Widths, character codes, register indexes and the hand-off record between
// the binary-to-BCD converter and the character emitter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

    // Input magnitude and BCD geometry
    localparam int MAG_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(MAG_W);
    localparam int ND_W       = $clog2(NUM_DIGITS + 1);

    // Register widths
    localparam int MINW_W = 6;
    localparam int CHAR_W = 8;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] PAD_RESET  = 8'h62;

    // Configuration register indexes
    localparam logic REG_FIELD_WIDTH = 1'b0;
    localparam logic REG_PAD_CHAR    = 1'b1;

    // Converted number handed to the emitter
    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic             neg;
        logic [ND_W-1:0]  num_digits;
    } conv_result_t;

endpackage

>>> hw/rtl/sitoa_conv.sv
// ----------------------------------------------------------------------------
// sitoa_conv: bit-serial binary to BCD converter
// Takes the magnitude of a signed value and shifts it into a BCD register
// one bit per cycle (shift-and-add-3), then holds the result for the emitter.
// ----------------------------------------------------------------------------
module sitoa_conv
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [sitoa_pkg::MAG_W-1:0] value,
    input  logic                            take,
    output logic                            idle,
    output logic                            done,
    output sitoa_pkg::conv_result_t         result
);

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_RUN  = 3'b010,
        C_DONE = 3'b100
    } conv_state_t;

    conv_state_t                     state_reg, state_next;
    logic [sitoa_pkg::MAG_W-1:0]     mag_reg, mag_next;
    logic [sitoa_pkg::BCD_W-1:0]     bcd_reg, bcd_next;
    logic                            neg_reg, neg_next;
    logic [sitoa_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [sitoa_pkg::BCD_W-1:0]     bcd_adj;
    logic [sitoa_pkg::ND_W-1:0]      num_digits;

    // Add 3 to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < sitoa_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Count significant digits: highest nonzero digit, at least one
    always_comb
    begin
        num_digits = sitoa_pkg::ND_W'(1);
        for (int i = 0; i < sitoa_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
            begin
                num_digits = sitoa_pkg::ND_W'(i + 1);
            end
        end
    end

    // Sequence the conversion
    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    neg_next   = value[sitoa_pkg::MAG_W-1];
                    mag_next   = value[sitoa_pkg::MAG_W-1] ?
                                 (sitoa_pkg::MAG_W'(0) - value) : value;
                    bcd_next   = '0;
                    cnt_next   = sitoa_pkg::CNT_W'(sitoa_pkg::MAG_W - 1);
                    state_next = C_RUN;
                end
            end
            C_RUN:
            begin
                bcd_next = {bcd_adj[sitoa_pkg::BCD_W-2:0], mag_reg[sitoa_pkg::MAG_W-1]};
                mag_next = {mag_reg[sitoa_pkg::MAG_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = C_DONE;
                end
            end
            C_DONE:
            begin
                if (take)
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
    end

    assign idle              = (state_reg == C_IDLE);
    assign done              = (state_reg == C_DONE);
    assign result.bcd        = bcd_reg;
    assign result.neg        = neg_reg;
    assign result.num_digits = num_digits;

endmodule

>>> hw/rtl/sitoa_emit.sv
// ----------------------------------------------------------------------------
// sitoa_emit: character emitter
// Walks pad characters, the minus sign and the BCD digits out one character
// per cycle on the result stream while it is ready, marking the final digit.
// ----------------------------------------------------------------------------
module sitoa_emit
#(
    parameter int MAX_WIDTH = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              conv_done,
    input  sitoa_pkg::conv_result_t           conv_result,
    input  logic [sitoa_pkg::MINW_W-1:0]      field_width,
    input  logic [sitoa_pkg::CHAR_W-1:0]      pad_char,
    output logic                              load,
    output logic                              tvalid,
    input  logic                              tready,
    output logic [sitoa_pkg::CHAR_W-1:0]      tdata,
    output logic                              tlast
);

    localparam int CW = ($clog2(MAX_WIDTH + 1) > sitoa_pkg::MINW_W) ?
                        $clog2(MAX_WIDTH + 1) : sitoa_pkg::MINW_W;

    typedef enum logic [3:0] {
        E_IDLE  = 4'b0001,
        E_PAD   = 4'b0010,
        E_SIGN  = 4'b0100,
        E_DIGIT = 4'b1000
    } emit_state_t;

    emit_state_t                   state_reg, state_next;
    logic [CW-1:0]                 pad_cnt_reg, pad_cnt_next;
    logic [sitoa_pkg::ND_W-1:0]    idx_reg, idx_next;
    logic [sitoa_pkg::BCD_W-1:0]   bcd_reg, bcd_next;
    logic                          neg_reg, neg_next;
    logic [CW-1:0]                 text_len;
    logic [CW-1:0]                 width_clamp;
    logic [CW-1:0]                 pads;
    logic                          fire;
    logic                          last_fire;

    assign fire      = tvalid && tready;
    assign last_fire = fire && tlast;
    assign load      = conv_done && ((state_reg == E_IDLE) || last_fire);

    // Padding needed for the incoming number
    always_comb
    begin
        text_len = CW'(conv_result.num_digits) + CW'(conv_result.neg);
        if (CW'(field_width) > CW'(MAX_WIDTH))
        begin
            width_clamp = CW'(MAX_WIDTH);
        end
        else
        begin
            width_clamp = CW'(field_width);
        end
        pads = (width_clamp > text_len) ? (width_clamp - text_len) : '0;
    end

    // Advance through pad, sign and digit phases
    always_comb
    begin
        state_next   = state_reg;
        pad_cnt_next = pad_cnt_reg;
        idx_next     = idx_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        if (load)
        begin
            bcd_next     = conv_result.bcd;
            neg_next     = conv_result.neg;
            idx_next     = conv_result.num_digits - 1'b1;
            pad_cnt_next = pads;
            if (pads != '0)
            begin
                state_next = E_PAD;
            end
            else if (conv_result.neg)
            begin
                state_next = E_SIGN;
            end
            else
            begin
                state_next = E_DIGIT;
            end
        end
        else if (fire)
        begin
            case (state_reg)
                E_PAD:
                begin
                    pad_cnt_next = pad_cnt_reg - 1'b1;
                    if (pad_cnt_reg == CW'(1))
                    begin
                        state_next = neg_reg ? E_SIGN : E_DIGIT;
                    end
                end
                E_SIGN:
                begin
                    state_next = E_DIGIT;
                end
                E_DIGIT:
                begin
                    idx_next = idx_reg - 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = E_IDLE;
                    end
                end
                default:
                begin
                    state_next = E_IDLE;
                end
            endcase
        end
    end

    // Drive the current character
    always_comb
    begin
        tdata = sitoa_pkg::CHAR_ZERO;
        case (state_reg)
            E_PAD:   tdata = pad_char;
            E_SIGN:  tdata = sitoa_pkg::CHAR_MINUS;
            E_DIGIT: tdata = sitoa_pkg::CHAR_ZERO | {4'd0, bcd_reg[{idx_reg, 2'b00} +: 4]};
            default: tdata = sitoa_pkg::CHAR_ZERO;
        endcase
    end

    assign tvalid = (state_reg != E_IDLE);
    assign tlast  = (state_reg == E_DIGIT) && (idx_reg == '0);

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold counters and digits
    always_ff @(posedge clk)
    begin
        pad_cnt_reg <= pad_cnt_next;
        idx_reg     <= idx_next;
        bcd_reg     <= bcd_next;
        neg_reg     <= neg_next;
    end

endmodule

>>> hw/rtl/signed_int_to_padded_decimal_text.sv
// ----------------------------------------------------------------------------
// signed_int_to_padded_decimal_text: signed integer to decimal ASCII text
// Converts a signed 32-bit integer to right-justified decimal characters.
// ----------------------------------------------------------------------------
// Each request carries one signed 32-bit value; the block answers with its
// decimal text on the result stream, one character per cycle while the result
// side is ready, most significant first: pad characters up to the minimum
// width register (clamped to MAX_WIDTH), a minus sign for negative values,
// then the digits, tlast on the final digit. The binary-to-BCD converter
// shifts one input bit per cycle: it takes the value, converts it and then
// hands it off to the emitter; the next value is accepted once the hand-off
// is done, and its conversion overlaps the emission of the previous text.
module signed_int_to_padded_decimal_text
#(
    parameter int MAX_WIDTH = 32
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic signed [sitoa_pkg::MAG_W-1:0] s_axis_tdata,   // [31:0] value
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [sitoa_pkg::CHAR_W-1:0]       m_axis_tdata,   // [7:0] char_out
    output logic                               m_axis_tlast,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [sitoa_pkg::CHAR_W-1:0]       cfg_data
);

    logic [sitoa_pkg::MINW_W-1:0] field_width_reg;
    logic [sitoa_pkg::CHAR_W-1:0] pad_char_reg;
    logic                         conv_idle;
    logic                         conv_done;
    logic                         load;
    logic                         in_fire;
    sitoa_pkg::conv_result_t      conv_result;

    assign s_axis_tready = conv_idle;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_width_reg <= '0;
            pad_char_reg    <= sitoa_pkg::PAD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sitoa_pkg::REG_FIELD_WIDTH: field_width_reg <= cfg_data[sitoa_pkg::MINW_W-1:0];
                sitoa_pkg::REG_PAD_CHAR:    pad_char_reg    <= cfg_data;
                default:                    pad_char_reg    <= pad_char_reg;
            endcase
        end
    end

    sitoa_conv u_conv
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_fire),
        .value  (s_axis_tdata),
        .take   (load),
        .idle   (conv_idle),
        .done   (conv_done),
        .result (conv_result)
    );

    sitoa_emit #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_emit
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .conv_done   (conv_done),
        .conv_result (conv_result),
        .field_width (field_width_reg),
        .pad_char    (pad_char_reg),
        .load        (load),
        .tvalid      (m_axis_tvalid),
        .tready      (m_axis_tready),
        .tdata       (m_axis_tdata),
        .tlast       (m_axis_tlast)
    );

    // A new request starts a conversion, so the input closes next cycle
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("input still ready after a request was taken");

    // The final character is always a decimal digit
    a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
        (m_axis_tdata >= sitoa_pkg::CHAR_ZERO &&
         m_axis_tdata <= sitoa_pkg::CHAR_ZERO + 8'd9))
        else $error("final character is not a digit");

    // Hand-off only happens while a converted number is held
    a_load_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (conv_done && !s_axis_tready))
        else $error("emitter loaded without a finished conversion");

endmodule
